// ===== design/hchacha_pkg.sv =====
// ----------------------------------------------------------------------------
// hchacha_pkg
// Shared types, constants and the per-stage round step for the HChaCha20
// subkey derivation pipeline.
// ----------------------------------------------------------------------------
package hchacha_pkg;

    typedef logic [31:0]        word_t;
    typedef logic [15:0][31:0]  state_t;
    typedef logic [63:0]        dword_t;

    // Round count and pipeline shape: four add/xor/rotate steps per half
    // round, two half rounds (column, diagonal) per double round.
    localparam int unsigned DOUBLE_ROUNDS  = 10;
    localparam int unsigned STEPS_PER_HALF = 4;
    localparam int unsigned NUM_STAGES     = DOUBLE_ROUNDS * 2 * STEPS_PER_HALF;

    // Configuration register file
    localparam int unsigned NUM_KEY_REGS = 4;
    localparam int unsigned CFG_ADDR_W   = $clog2(NUM_KEY_REGS);
    localparam int unsigned CFG_DATA_W   = 64;

    // Channel widths
    localparam int unsigned S_TDATA_W = 128;
    localparam int unsigned M_TDATA_W = 256;

    // Fixed state words 0 to 3
    localparam word_t SIGMA0 = 32'h61707865;
    localparam word_t SIGMA1 = 32'h3320646e;
    localparam word_t SIGMA2 = 32'h79622d32;
    localparam word_t SIGMA3 = 32'h6b206574;

    // Rotate amounts of the four steps of a quarter round
    localparam int unsigned ROT_AMT [STEPS_PER_HALF] = '{16, 12, 8, 7};

    function automatic word_t rotl32(word_t v, int unsigned n);
        rotl32 = (v << n) | (v >> (32 - n));
    endfunction

    // One add/xor/rotate step applied to all four quarter rounds at once.
    // sub selects the step inside the quarter round, diag the lane pattern.
    function automatic state_t round_step(state_t s, int unsigned sub, logic diag);
        state_t      r;
        logic [1:0]  q;
        logic [1:0]  shift;
        logic [3:0]  ia, ib, ic, id;
        logic [3:0]  xi, yi, zi;
        word_t       sum;
        r     = s;
        shift = {1'b0, diag};
        for (int l = 0; l < 4; l++) begin
            q  = l[1:0];
            ia = {2'd0, q};
            ib = {2'd1, q + shift};
            ic = {2'd2, q + (shift << 1)};
            id = {2'd3, q + shift + (shift << 1)};
            if (sub == 0 || sub == 2) begin
                xi = ia;
                yi = ib;
                zi = id;
            end else begin
                xi = ic;
                yi = id;
                zi = ib;
            end
            sum   = r[xi] + r[yi];
            r[xi] = sum;
            r[zi] = rotl32(r[zi] ^ sum, ROT_AMT[sub]);
        end
        round_step = r;
    endfunction

endpackage

// ===== design/hchacha20_subkey_derivation_top.sv =====
// ----------------------------------------------------------------------------
// hchacha20_subkey_derivation_top
// HChaCha20 subkey derivation: 128-bit nonce in, 256-bit subkey out.
// ----------------------------------------------------------------------------
// The block takes one nonce beat per clock unless stalled, and returns one
// subkey beat per nonce, in order. Each pipeline stage performs one
// add/xor/rotate step of all four quarter rounds in parallel, so the 10
// double rounds take 80 stages. The first stage loads on the edge that
// accepts the nonce; the state then moves through the stages in order and
// on into the output register. The 256-bit key lives in four 64-bit registers
// written through the cfg port (reset to zero); write them only while no nonce
// is in flight.
// While a result waits on the output, the pipeline keeps accepting and
// advancing until its last stage also holds a result; only then is
// s_axis_tready dropped.
module hchacha20_subkey_derivation_top (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    // configuration write port
    input  logic                                  cfg_we,
    input  logic [hchacha_pkg::CFG_ADDR_W-1:0]    cfg_addr,
    input  logic [hchacha_pkg::CFG_DATA_W-1:0]    cfg_wdata,
    // nonce stream
    input  logic                                  s_axis_tvalid,
    output logic                                  s_axis_tready,
    // tdata from bit 0: nonce_low[63:0], nonce_high[63:0]
    input  logic [hchacha_pkg::S_TDATA_W-1:0]     s_axis_tdata,
    // subkey stream
    output logic                                  m_axis_tvalid,
    input  logic                                  m_axis_tready,
    // tdata from bit 0: subkey_word0, subkey_word1, subkey_word2, subkey_word3
    output logic [hchacha_pkg::M_TDATA_W-1:0]     m_axis_tdata
);
    import hchacha_pkg::*;

    localparam int unsigned LAST = NUM_STAGES - 1;

    dword_t                  key_reg [NUM_KEY_REGS];
    logic [NUM_STAGES-1:0]   valid_reg;
    state_t                  stage_reg [NUM_STAGES];
    logic                    m_tvalid_reg;
    logic [M_TDATA_W-1:0]    m_tdata_reg;
    logic                    pipe_en;
    state_t                  init_state;

    // Key registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NUM_KEY_REGS; i++) begin
                key_reg[i] <= '0;
            end
        end else if (cfg_we) begin
            key_reg[cfg_addr] <= cfg_wdata;
        end
    end

    // Advance the pipeline unless the last stage and the output both hold results and the output is not taken
    assign pipe_en       = !valid_reg[LAST] || !m_tvalid_reg || m_axis_tready;
    assign s_axis_tready = pipe_en;

    // Build the starting state from constants, key and nonce
    always_comb begin
        init_state[0] = SIGMA0;
        init_state[1] = SIGMA1;
        init_state[2] = SIGMA2;
        init_state[3] = SIGMA3;
        for (int i = 0; i < NUM_KEY_REGS; i++) begin
            init_state[4 + 2 * i] = key_reg[i][31:0];
            init_state[5 + 2 * i] = key_reg[i][63:32];
        end
        init_state[12] = s_axis_tdata[31:0];
        init_state[13] = s_axis_tdata[63:32];
        init_state[14] = s_axis_tdata[95:64];
        init_state[15] = s_axis_tdata[127:96];
    end

    // Valid bits travel with the data
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (pipe_en) begin
            valid_reg <= {valid_reg[NUM_STAGES-2:0], s_axis_tvalid};
        end
    end

    // Round stages: one add/xor/rotate step each
    for (genvar g = 0; g < NUM_STAGES; g++) begin : g_stage
        localparam int unsigned SUB  = g % STEPS_PER_HALF;
        localparam logic        DIAG = ((g / STEPS_PER_HALF) % 2) == 1;
        state_t stage_in;

        if (g == 0) begin : g_head
            assign stage_in = init_state;
        end else begin : g_body
            assign stage_in = stage_reg[g-1];
        end

        always_ff @(posedge aclk) begin
            if (pipe_en) begin
                stage_reg[g] <= round_step(stage_in, SUB, DIAG);
            end
        end
    end

    // Output register: load a finished result, drop it once taken
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (pipe_en && valid_reg[LAST]) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_axis_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (pipe_en && valid_reg[LAST]) begin
            m_tdata_reg <= {stage_reg[LAST][15], stage_reg[LAST][14],
                            stage_reg[LAST][13], stage_reg[LAST][12],
                            stage_reg[LAST][3],  stage_reg[LAST][2],
                            stage_reg[LAST][1],  stage_reg[LAST][0]};
        end
    end

    assign m_axis_tvalid = m_tvalid_reg;
    assign m_axis_tdata  = m_tdata_reg;

`ifndef SYNTHESIS
    // A stall happens only with a full last stage and a waiting output
    a_stall_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        !pipe_en |-> (valid_reg[LAST] && m_tvalid_reg && !m_axis_tready))
        else $error("pipeline stalled without a blocked result");

    // An accepted nonce enters the first stage
    a_accept_enters: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_axis_tvalid && s_axis_tready) |=> valid_reg[0])
        else $error("accepted beat did not enter the pipeline");

    // A stalled pipeline holds its valid bits
    a_stall_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        !pipe_en |=> $stable(valid_reg))
        else $error("valid bits moved during a stall");

    // A finished result always reaches the output register
    a_result_lands: assert property (@(posedge aclk) disable iff (!aresetn)
        (pipe_en && valid_reg[LAST]) |=> m_tvalid_reg)
        else $error("result left the last stage but was not presented");
`endif

endmodule

// ===== tb/hchacha20_subkey_derivation_top_test.sv =====
// ----------------------------------------------------------------------------
// hchacha20_subkey_derivation_top_test
// Self-checking bench for the HChaCha20 subkey pipeline. Nonce beats are
// streamed in under varying key settings and back-pressure patterns. Each
// accepted nonce is run through a behavioral HChaCha20 in the bench. Every
// subkey beat is compared, one 64-bit word at a time, with the oldest
// outstanding prediction.
// ----------------------------------------------------------------------------
module hchacha20_subkey_derivation_top_test;

    import hchacha_pkg::*;

    typedef logic [15:0][31:0] chacha_state_t;
    typedef logic [3:0][63:0]  key_bank_t;

    // Key register indexes
    localparam logic [CFG_ADDR_W-1:0] KEY_WORD0 = CFG_ADDR_W'(0);
    localparam logic [CFG_ADDR_W-1:0] KEY_WORD1 = CFG_ADDR_W'(1);
    localparam logic [CFG_ADDR_W-1:0] KEY_WORD2 = CFG_ADDR_W'(2);
    localparam logic [CFG_ADDR_W-1:0] KEY_WORD3 = CFG_ADDR_W'(3);

    // "expand 32-byte k"
    localparam logic [31:0] EXPAND0 = 32'h61707865;
    localparam logic [31:0] EXPAND1 = 32'h3320646e;
    localparam logic [31:0] EXPAND2 = 32'h79622d32;
    localparam logic [31:0] EXPAND3 = 32'h6b206574;

    localparam int NUM_DOUBLE_ROUNDS = 10;
    localparam int PIPE_LATENCY      = 80;
    localparam int CYCLE_LIMIT       = 400000;
    localparam int RANDOM_PER_PHASE  = 420;
    localparam int MAX_REPORTS       = 10;

    logic                    aclk          = 1'b0;
    logic                    aresetn       = 1'b0;
    logic                    cfg_we        = 1'b0;
    logic [CFG_ADDR_W-1:0]   cfg_addr      = '0;
    logic [CFG_DATA_W-1:0]   cfg_wdata     = '0;
    logic                    s_axis_tvalid = 1'b0;
    logic                    s_axis_tready;
    logic [S_TDATA_W-1:0]    s_axis_tdata  = '0;
    logic                    m_axis_tvalid;
    logic                    m_axis_tready = 1'b0;
    logic [M_TDATA_W-1:0]    m_axis_tdata;

    // Bench copy of the key registers
    key_bank_t               key_bank = '0;

    logic [S_TDATA_W-1:0]    nonce_queue[$];
    logic [M_TDATA_W-1:0]    subkey_due[$];

    int                      send_idle_pct  = 0;
    int                      recv_stall_pct = 0;
    int                      subkey_errors  = 0;
    int                      cycle_count    = 0;

    hchacha20_subkey_derivation_top u_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_we        (cfg_we),
        .cfg_addr      (cfg_addr),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #4 aclk = ~aclk;

    // ------------------------------------------------------------------------
    // HChaCha20 predictor
    // ------------------------------------------------------------------------
    function automatic logic [31:0] rotate_left(logic [31:0] v, int n);
        return (v << n) | (v >> (32 - n));
    endfunction

    function automatic chacha_state_t quarter_mix(chacha_state_t st, int a, int b,
                                                  int c, int d);
        st[a] = st[a] + st[b];  st[d] = rotate_left(st[d] ^ st[a], 16);
        st[c] = st[c] + st[d];  st[b] = rotate_left(st[b] ^ st[c], 12);
        st[a] = st[a] + st[b];  st[d] = rotate_left(st[d] ^ st[a], 8);
        st[c] = st[c] + st[d];  st[b] = rotate_left(st[b] ^ st[c], 7);
        return st;
    endfunction

    function automatic logic [M_TDATA_W-1:0] derive_subkey(key_bank_t key,
                                                           logic [S_TDATA_W-1:0] nonce);
        chacha_state_t st;
        st[0] = EXPAND0;
        st[1] = EXPAND1;
        st[2] = EXPAND2;
        st[3] = EXPAND3;
        for (int i = 0; i < 4; i++) begin
            st[4 + 2 * i] = key[i][31:0];
            st[5 + 2 * i] = key[i][63:32];
        end
        for (int i = 0; i < 4; i++)
            st[12 + i] = nonce[32 * i +: 32];
        for (int r = 0; r < NUM_DOUBLE_ROUNDS; r++) begin
            // columns
            st = quarter_mix(st, 0, 4, 8, 12);
            st = quarter_mix(st, 1, 5, 9, 13);
            st = quarter_mix(st, 2, 6, 10, 14);
            st = quarter_mix(st, 3, 7, 11, 15);
            // diagonals
            st = quarter_mix(st, 0, 5, 10, 15);
            st = quarter_mix(st, 1, 6, 11, 12);
            st = quarter_mix(st, 2, 7, 8, 13);
            st = quarter_mix(st, 3, 4, 9, 14);
        end
        return {st[15], st[14], st[13], st[12], st[3], st[2], st[1], st[0]};
    endfunction

    // ------------------------------------------------------------------------
    // Nonce driver: record accepted beats, then present the next one
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready)
                subkey_due.push_back(derive_subkey(key_bank, s_axis_tdata));
            if (!s_axis_tvalid || s_axis_tready) begin
                if (nonce_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    s_axis_tdata  <= nonce_queue.pop_front();
                    s_axis_tvalid <= 1'b1;
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Subkey monitor: check each beat word by word, randomize back-pressure
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin
        logic [M_TDATA_W-1:0] want;
        if (!aresetn) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (subkey_due.size() == 0) begin
                    subkey_errors = subkey_errors + 1;
                    if (subkey_errors <= MAX_REPORTS)
                        $display("subkey beat %h with no nonce outstanding", m_axis_tdata);
                end else begin
                    want = subkey_due.pop_front();
                    for (int f = 0; f < 4; f++) begin
                        if (m_axis_tdata[64 * f +: 64] !== want[64 * f +: 64]) begin
                            subkey_errors = subkey_errors + 1;
                            if (subkey_errors <= MAX_REPORTS)
                                $display("subkey_word%0d: expected %h, got %h", f,
                                         want[64 * f +: 64], m_axis_tdata[64 * f +: 64]);
                        end
                    end
                end
            end
            m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Watchdog
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("hchacha20_subkey_derivation_top_test: errors");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------
    // Hold until every queued nonce is accepted and every subkey returned.
    task automatic wait_drained();
        @(negedge aclk);
        while (nonce_queue.size() != 0 || s_axis_tvalid || subkey_due.size() != 0)
            @(negedge aclk);
    endtask

    task automatic write_key_reg(logic [CFG_ADDR_W-1:0] idx, logic [63:0] value);
        @(posedge aclk);
        cfg_we        <= 1'b1;
        cfg_addr      <= idx;
        cfg_wdata     <= value;
        key_bank[idx] =  value;
    endtask

    // Load all four key registers in back-to-back cycles, then release the port.
    task automatic load_key(logic [63:0] k0, logic [63:0] k1, logic [63:0] k2,
                            logic [63:0] k3);
        write_key_reg(KEY_WORD0, k0);
        write_key_reg(KEY_WORD1, k1);
        write_key_reg(KEY_WORD2, k2);
        write_key_reg(KEY_WORD3, k3);
        @(posedge aclk);
        cfg_we <= 1'b0;
        @(negedge aclk);
    endtask

    function automatic logic [63:0] rand_dword();
        return {$urandom, $urandom};
    endfunction

    // Mostly fully random nonces, with some halves pinned to all-zero or all-one.
    task automatic queue_random_nonces(int count);
        logic [63:0] lo_half;
        logic [63:0] hi_half;
        for (int n = 0; n < count; n++) begin
            lo_half = rand_dword();
            hi_half = rand_dword();
            case ($urandom_range(15))
                0: lo_half = '0;
                1: hi_half = '1;
                2: lo_half = '1;
                3: hi_half = '0;
                default: ;
            endcase
            nonce_queue.push_back({hi_half, lo_half});
        end
    endtask

    // ------------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------------
    initial begin
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Directed: reset key of all zeros, extreme and walking-bit nonces
        nonce_queue.push_back('0);
        nonce_queue.push_back('1);
        nonce_queue.push_back({64'h0, {64{1'b1}}});
        nonce_queue.push_back({{64{1'b1}}, 64'h0});
        nonce_queue.push_back({32{4'h5}});
        nonce_queue.push_back({32{4'ha}});
        nonce_queue.push_back(128'h1);
        nonce_queue.push_back(128'h1 << 63);
        nonce_queue.push_back(128'h1 << 64);
        nonce_queue.push_back(128'h1 << 127);
        wait_drained();

        // Directed: all-ones key
        load_key('1, '1, '1, '1);
        nonce_queue.push_back('0);
        nonce_queue.push_back('1);
        nonce_queue.push_back({32{4'h5}});
        nonce_queue.push_back({32{4'ha}});
        wait_drained();

        // Published vector key 00..1f, then random nonces; sender mostly idle
        load_key(64'h0706050403020100, 64'h0f0e0d0c0b0a0908,
                 64'h1716151413121110, 64'h1f1e1d1c1b1a1918);
        nonce_queue.push_back({64'h2759413100000000, 64'h4a00000009000000});
        send_idle_pct = 73;
        queue_random_nonces(RANDOM_PER_PHASE);
        wait_drained();

        // Random key; receiver mostly stalled
        load_key(rand_dword(), rand_dword(), rand_dword(), rand_dword());
        send_idle_pct  = 0;
        recv_stall_pct = 73;
        queue_random_nonces(RANDOM_PER_PHASE);
        wait_drained();

        // Mixed extreme key; both sides idle part of the time
        load_key('1, '0, '1, rand_dword());
        send_idle_pct  = 35;
        recv_stall_pct = 35;
        queue_random_nonces(RANDOM_PER_PHASE);
        wait_drained();

        // Back to an all-zero key at full rate
        load_key('0, '0, '0, '0);
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        queue_random_nonces(RANDOM_PER_PHASE);
        wait_drained();

        // Let the pipeline settle so stray beats are caught
        repeat (PIPE_LATENCY + 40) @(posedge aclk);
        if (subkey_errors == 0 && subkey_due.size() == 0)
            $display("hchacha20_subkey_derivation_top_test: clean");
        else
            $display("hchacha20_subkey_derivation_top_test: errors");
        $finish;
    end

endmodule

// ===== sim.f =====
design/hchacha_pkg.sv
design/hchacha20_subkey_derivation_top.sv
tb/hchacha20_subkey_derivation_top_test.sv
